// File: rtl/ctc_pkg.sv
`timescale 1ns / 1ps

package ctc_pkg;

  // Field widths
  localparam int CMD_BITS  = 3;
  localparam int ID_BITS   = 8;
  localparam int MASK_BITS = 16;

  // Capability bits with a fixed meaning
  localparam logic [MASK_BITS-1:0] BIT_TASK_CREATE = 16'h0100;
  localparam logic [MASK_BITS-1:0] BIT_GRANT       = 16'h0400;
  localparam logic [MASK_BITS-1:0] BIT_REVOKE      = 16'h0800;
  localparam logic [MASK_BITS-1:0] BIT_KERNEL      = 16'h1000;
  localparam logic [MASK_BITS-1:0] FULL_MASK       = 16'hFFFF;

  // Bits a child never inherits from its parent
  localparam logic [MASK_BITS-1:0] NO_INHERIT = BIT_GRANT | BIT_REVOKE | BIT_KERNEL;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_GRANT   = 3'd2,
    CMD_REVOKE  = 3'd3,
    CMD_CHECK   = 3'd4,
    CMD_GET     = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t                 command;
    logic [ID_BITS-1:0]   subject_id;
    logic [ID_BITS-1:0]   actor_id;
    logic [MASK_BITS-1:0] perm_mask;
  } request_t;

  typedef struct packed {
    logic                 ok;
    logic                 allowed;
    logic [MASK_BITS-1:0] capabilities;
  } result_t;

  // One table entry
  typedef struct packed {
    logic                 active;
    logic [MASK_BITS-1:0] mask;
  } entry_t;

  localparam entry_t ENTRY_ROOT  = '{active: 1'b1, mask: FULL_MASK};
  localparam entry_t ENTRY_EMPTY = '{active: 1'b0, mask: '0};

endpackage

// File: rtl/capability_table_checker.sv
`timescale 1ns / 1ps

// Channel  | Ports                  | Handshake
// ---------+------------------------+--------------------------------------------
// command  | start, busy, request   | word taken at an edge with start && !busy
// result   | done, result           | word valid for the single cycle done is high
//
// Timing: one command word per cycle, sustained; busy stays low. A result
// follows its command through the registered table read at the subject and
// actor addresses, then the decision, the table write and the result
// register.
// Reset clears per-entry fill bits at once; an entry never written reads as
// its reset value (task 0 active with all bits, others empty). No clearing pass.
// The receiver cannot stall; a word issued back to back with the write of the
// previous one sees that write through a bypass.

module capability_table_checker #(
  parameter int TASK_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ctc_pkg::request_t  request,
  output logic               done,
  output ctc_pkg::result_t   result
);

  localparam int ID_W = $clog2(TASK_SLOTS);

  // Table storage and fill bits
  ctc_pkg::entry_t         mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]   filled;

  // Read stage
  logic                    s1_valid;
  ctc_pkg::request_t       s1_req;
  ctc_pkg::entry_t         rd_subj;
  ctc_pkg::entry_t         rd_actor;

  // Last write, kept for the bypass
  logic                    lw_en;
  logic [ID_W-1:0]         lw_addr;
  ctc_pkg::entry_t         lw_data;

  // Decision stage
  logic                    accept;
  logic [ID_W-1:0]         subj_idx;
  logic [ID_W-1:0]         actor_idx;
  logic                    subj_in;
  logic                    actor_in;
  ctc_pkg::entry_t         subj_e;
  ctc_pkg::entry_t         actor_e;
  logic [ctc_pkg::MASK_BITS-1:0] need;
  logic                    actor_auth;
  logic                    subj_auth;
  logic                    wr_en;
  ctc_pkg::entry_t         wr_data;
  ctc_pkg::result_t        result_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capture the command word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_req <= request;
    end
  end

  // Table write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[subj_idx] <= wr_data;
    end
    if (accept) begin
      rd_subj  <= mem[request.subject_id[ID_W-1:0]];
      rd_actor <= mem[request.actor_id[ID_W-1:0]];
    end
  end

  // Mark written entries; hold the last write for the bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      lw_en  <= 1'b0;
    end else begin
      lw_en <= wr_en;
      if (wr_en) begin
        filled[subj_idx] <= 1'b1;
      end
    end
    if (wr_en) begin
      lw_addr <= subj_idx;
      lw_data <= wr_data;
    end
  end

  assign subj_idx  = s1_req.subject_id[ID_W-1:0];
  assign actor_idx = s1_req.actor_id[ID_W-1:0];
  assign subj_in   = 32'(s1_req.subject_id) < TASK_SLOTS;
  assign actor_in  = 32'(s1_req.actor_id) < TASK_SLOTS;

  // Resolve entries: bypass, else stored data, else reset value
  always_comb begin
    if (lw_en && lw_addr == subj_idx) begin
      subj_e = lw_data;
    end else if (filled[subj_idx]) begin
      subj_e = rd_subj;
    end else begin
      subj_e = (subj_idx == '0) ? ctc_pkg::ENTRY_ROOT : ctc_pkg::ENTRY_EMPTY;
    end
    if (lw_en && lw_addr == actor_idx) begin
      actor_e = lw_data;
    end else if (filled[actor_idx]) begin
      actor_e = rd_actor;
    end else begin
      actor_e = (actor_idx == '0) ? ctc_pkg::ENTRY_ROOT : ctc_pkg::ENTRY_EMPTY;
    end
  end

  // Operation bit the actor must hold
  always_comb begin
    unique case (s1_req.command)
      ctc_pkg::CMD_CREATE: need = ctc_pkg::BIT_TASK_CREATE;
      ctc_pkg::CMD_GRANT:  need = ctc_pkg::BIT_GRANT;
      ctc_pkg::CMD_REVOKE: need = ctc_pkg::BIT_REVOKE;
      default:             need = '0;
    endcase
  end

  // Authority checks
  assign actor_auth = actor_in && actor_e.active &&
                      ((actor_e.mask & ctc_pkg::BIT_KERNEL) != '0 ||
                       ((actor_e.mask & need) == need));
  assign subj_auth  = subj_in && subj_e.active &&
                      ((subj_e.mask & ctc_pkg::BIT_KERNEL) != '0 ||
                       ((subj_e.mask & s1_req.perm_mask) == s1_req.perm_mask));

  // Decide write and result
  always_comb begin
    wr_en       = 1'b0;
    wr_data     = subj_e;
    result_next = '0;
    unique case (s1_req.command)
      ctc_pkg::CMD_CREATE: begin
        if (subj_in && actor_auth && !subj_e.active) begin
          wr_en          = 1'b1;
          wr_data.active = 1'b1;
          wr_data.mask   = s1_req.perm_mask | (actor_e.mask & ~ctc_pkg::NO_INHERIT);
          result_next.ok = 1'b1;
        end
      end
      ctc_pkg::CMD_DESTROY: begin
        if (subj_in && subj_idx != '0) begin
          wr_en          = 1'b1;
          wr_data        = ctc_pkg::ENTRY_EMPTY;
          result_next.ok = 1'b1;
        end
      end
      ctc_pkg::CMD_GRANT: begin
        if (subj_in && actor_auth && subj_e.active) begin
          wr_en          = 1'b1;
          wr_data.mask   = subj_e.mask | s1_req.perm_mask;
          result_next.ok = 1'b1;
        end
      end
      ctc_pkg::CMD_REVOKE: begin
        if (subj_in && actor_auth && subj_idx != '0 && subj_e.active) begin
          wr_en          = 1'b1;
          wr_data.mask   = subj_e.mask & ~s1_req.perm_mask;
          result_next.ok = 1'b1;
        end
      end
      ctc_pkg::CMD_CHECK: begin
        result_next.allowed = subj_auth;
      end
      ctc_pkg::CMD_GET: begin
        if (subj_in && subj_e.active) begin
          result_next.capabilities = subj_e.mask;
        end
      end
      default: begin
      end
    endcase
    if (!s1_valid) begin
      wr_en = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      result <= result_next;
    end
  end

  // Every taken word reaches the read stage, then the result
  a_start_to_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach the read stage");

  a_s1_to_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("read stage word produced no result");

  // ok only for table-changing commands
  a_ok_cmd: assert property (@(posedge clk) disable iff (rst)
    done && result.ok |->
      ($past(s1_req.command) == ctc_pkg::CMD_CREATE ||
       $past(s1_req.command) == ctc_pkg::CMD_DESTROY ||
       $past(s1_req.command) == ctc_pkg::CMD_GRANT ||
       $past(s1_req.command) == ctc_pkg::CMD_REVOKE))
    else $error("ok raised for a non-modifying command");

  // A check result carries nothing else
  a_allowed_alone: assert property (@(posedge clk) disable iff (rst)
    done && result.allowed |-> !result.ok && result.capabilities == '0)
    else $error("check result mixed with other fields");

  // Task 0 never goes inactive
  a_root_alive: assert property (@(posedge clk) disable iff (rst)
    wr_en && subj_idx == '0 |-> wr_data.active)
    else $error("task 0 deactivated");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS          = 64;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 6;

  // Command codes the block does not define
  localparam logic [ctc_pkg::CMD_BITS-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [ctc_pkg::CMD_BITS-1:0] CMD_SPARE_B = 3'd7;

  // Directed rows either carry a typed-in result or defer to the predictor
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  ctc_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  ctc_pkg::result_t  result;

  capability_table_checker #(.TASK_SLOTS(SLOTS)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the capability table
  logic [ctc_pkg::MASK_BITS-1:0] cap_table [SLOTS];
  logic                          live_table [SLOTS];

  ctc_pkg::result_t expected_results [$];
  int               errors = 0;

  // Directed stimulus table
  ctc_pkg::request_t dir_req [$];
  bit                dir_typed [$];
  ctc_pkg::result_t  dir_result [$];

  int unsigned      sent_count = 0;
  int unsigned      total_items;
  int unsigned      burst_left = 0;
  int unsigned      gap_left = 0;
  bit               cur_typed = 1'b0;
  ctc_pkg::result_t cur_result = '0;
  ctc_pkg::result_t want;
  int unsigned      idle_cycles = 0;

  function automatic bit holds_authority(logic [ctc_pkg::ID_BITS-1:0] id,
                                         logic [ctc_pkg::MASK_BITS-1:0] need);
    if (id >= SLOTS) return 1'b0;
    if (!live_table[id]) return 1'b0;
    if ((cap_table[id] & ctc_pkg::BIT_KERNEL) != '0) return 1'b1;
    return (cap_table[id] & need) == need;
  endfunction

  // Apply one command word to the shadow table and return its result word
  function automatic ctc_pkg::result_t apply_command(ctc_pkg::request_t req);
    ctc_pkg::result_t              res;
    logic                          subj_ok;
    logic                          ids_ok;
    logic [ctc_pkg::ID_BITS-1:0]   s;
    logic [ctc_pkg::ID_BITS-1:0]   a;
    logic [ctc_pkg::MASK_BITS-1:0] inherit;
    res     = '0;
    s       = req.subject_id;
    a       = req.actor_id;
    subj_ok = s < SLOTS;
    ids_ok  = subj_ok && (a < SLOTS);
    case (req.command)
      ctc_pkg::CMD_CREATE: begin
        if (ids_ok && holds_authority(a, ctc_pkg::BIT_TASK_CREATE)) begin
          if (!live_table[s]) begin
            inherit      = cap_table[a] & ~ctc_pkg::NO_INHERIT;
            cap_table[s] = req.perm_mask | inherit;
            live_table[s] = 1'b1;
            res.ok       = 1'b1;
          end
        end
      end
      ctc_pkg::CMD_DESTROY: begin
        if (subj_ok && s != '0) begin
          live_table[s] = 1'b0;
          cap_table[s]  = '0;
          res.ok        = 1'b1;
        end
      end
      ctc_pkg::CMD_GRANT: begin
        if (ids_ok && holds_authority(a, ctc_pkg::BIT_GRANT)) begin
          if (live_table[s]) begin
            cap_table[s] = cap_table[s] | req.perm_mask;
            res.ok       = 1'b1;
          end
        end
      end
      ctc_pkg::CMD_REVOKE: begin
        if (ids_ok && holds_authority(a, ctc_pkg::BIT_REVOKE) && s != '0) begin
          if (live_table[s]) begin
            cap_table[s] = cap_table[s] & ~req.perm_mask;
            res.ok       = 1'b1;
          end
        end
      end
      ctc_pkg::CMD_CHECK: begin
        res.allowed = holds_authority(s, req.perm_mask);
      end
      ctc_pkg::CMD_GET: begin
        if (subj_ok) begin
          if (live_table[s]) res.capabilities = cap_table[s];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_row(input logic [ctc_pkg::CMD_BITS-1:0] c,
                         input logic [ctc_pkg::ID_BITS-1:0] s,
                         input logic [ctc_pkg::ID_BITS-1:0] a,
                         input logic [ctc_pkg::MASK_BITS-1:0] m,
                         input bit t, input logic o = 1'b0, input logic al = 1'b0,
                         input logic [ctc_pkg::MASK_BITS-1:0] cp = '0);
    ctc_pkg::request_t req;
    ctc_pkg::result_t  res;
    req.command      = ctc_pkg::cmd_t'(c);
    req.subject_id   = s;
    req.actor_id     = a;
    req.perm_mask    = m;
    res.ok           = o;
    res.allowed      = al;
    res.capabilities = cp;
    dir_req.push_back(req);
    dir_typed.push_back(t);
    dir_result.push_back(res);
  endtask

  // Mostly a few low slots so tasks collide; sometimes any slot or out of range
  function automatic logic [ctc_pkg::ID_BITS-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return ctc_pkg::ID_BITS'($urandom_range(0, 7));
    if (r < 90) return ctc_pkg::ID_BITS'($urandom_range(0, SLOTS - 1));
    return ctc_pkg::ID_BITS'($urandom_range(0, 255));
  endfunction

  function automatic logic [ctc_pkg::MASK_BITS-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return ctc_pkg::MASK_BITS'($urandom);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return ctc_pkg::BIT_TASK_CREATE;
        1: return ctc_pkg::BIT_GRANT;
        2: return ctc_pkg::BIT_REVOKE;
        default: return ctc_pkg::BIT_KERNEL;
      endcase
    end
    if (r < 55) return '0;
    if (r < 62) return ctc_pkg::FULL_MASK;
    return ctc_pkg::MASK_BITS'($urandom) & ~ctc_pkg::BIT_KERNEL;
  endfunction

  function automatic ctc_pkg::request_t random_command();
    ctc_pkg::request_t req;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 22)      req.command = ctc_pkg::CMD_CREATE;
    else if (r < 36) req.command = ctc_pkg::CMD_DESTROY;
    else if (r < 50) req.command = ctc_pkg::CMD_GRANT;
    else if (r < 64) req.command = ctc_pkg::CMD_REVOKE;
    else if (r < 80) req.command = ctc_pkg::CMD_CHECK;
    else if (r < 96) req.command = ctc_pkg::CMD_GET;
    else if (r < 98) req.command = ctc_pkg::cmd_t'(CMD_SPARE_A);
    else             req.command = ctc_pkg::cmd_t'(CMD_SPARE_B);
    req.subject_id = pick_id();
    req.actor_id   = ($urandom_range(0, 99) < 35) ? '0 : pick_id();
    req.perm_mask  = pick_mask();
    return req;
  endfunction

  // Driver: take words at start && !busy, feed the predictor, present the next word
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cap_table[i]  = '0;
      live_table[i] = 1'b0;
    end
    cap_table[0]  = ctc_pkg::FULL_MASK;
    live_table[0] = 1'b1;

    // After reset
    add_row(ctc_pkg::CMD_GET,     8'd0,   8'd0,   16'h0000, TYPED, 1'b0, 1'b0,
            ctc_pkg::FULL_MASK);
    add_row(ctc_pkg::CMD_GET,     8'd1,   8'd0,   16'h0000, TYPED);
    add_row(ctc_pkg::CMD_CHECK,   8'd0,   8'd255, ctc_pkg::FULL_MASK, TYPED, 1'b0, 1'b1);
    add_row(ctc_pkg::CMD_CHECK,   8'd63,  8'd0,   16'h0000, TYPED);
    add_row(ctc_pkg::CMD_GET,     8'd255, 8'd255, ctc_pkg::FULL_MASK, TYPED);
    // Create, and create on an active or out-of-range slot
    add_row(ctc_pkg::CMD_CREATE,  8'd1,   8'd0,   16'h0003, TYPED, 1'b1);
    add_row(ctc_pkg::CMD_GET,     8'd1,   8'd0,   16'h0000, PREDICTED);
    add_row(ctc_pkg::CMD_CREATE,  8'd1,   8'd0,   16'h0000, TYPED);
    add_row(ctc_pkg::CMD_CREATE,  8'd64,  8'd0,   16'h0000, TYPED);
    add_row(ctc_pkg::CMD_CREATE,  8'd2,   8'd255, 16'h0000, TYPED);
    // Destroy of task 0, of an inactive slot, out of range
    add_row(ctc_pkg::CMD_DESTROY, 8'd0,   8'd0,   16'h0000, TYPED);
    add_row(ctc_pkg::CMD_DESTROY, 8'd63,  8'd17,  16'h0000, TYPED, 1'b1);
    add_row(ctc_pkg::CMD_DESTROY, 8'd255, 8'd255, ctc_pkg::FULL_MASK, TYPED);
    // Grant, grant to task 0, revoke on task 0 and on task 1, check, grant by task 1
    add_row(ctc_pkg::CMD_GRANT,   8'd1,   8'd0,   ctc_pkg::NO_INHERIT, TYPED, 1'b1);
    add_row(ctc_pkg::CMD_GRANT,   8'd0,   8'd1,   16'h0000, PREDICTED);
    add_row(ctc_pkg::CMD_REVOKE,  8'd0,   8'd0,   ctc_pkg::FULL_MASK, TYPED);
    add_row(ctc_pkg::CMD_REVOKE,  8'd1,   8'd0,   ctc_pkg::FULL_MASK, TYPED, 1'b1);
    add_row(ctc_pkg::CMD_CHECK,   8'd1,   8'd0,   16'h0000, PREDICTED);
    add_row(ctc_pkg::CMD_GRANT,   8'd1,   8'd1,   ctc_pkg::FULL_MASK, PREDICTED);
    // Grant or revoke on an inactive target
    add_row(ctc_pkg::CMD_GRANT,   8'd5,   8'd0,   16'h0001, TYPED);
    add_row(ctc_pkg::CMD_REVOKE,  8'd5,   8'd0,   16'h0001, TYPED);
    // Unknown commands, then create and read back slot 63
    add_row(CMD_SPARE_A,          8'd0,   8'd0,   ctc_pkg::FULL_MASK, TYPED);
    add_row(CMD_SPARE_B,          8'd255, 8'd255, ctc_pkg::FULL_MASK, TYPED);
    add_row(ctc_pkg::CMD_CREATE,  8'd63,  8'd0,   ctc_pkg::FULL_MASK, TYPED, 1'b1);
    add_row(ctc_pkg::CMD_GET,     8'd63,  8'd0,   16'h0000, PREDICTED);

    total_items = dir_req.size() + RANDOM_ITEMS;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_items) begin
      @(posedge clk);
      // Take the word on the bus
      if (start && !busy) begin
        want = apply_command(request);
        expected_results.push_back(cur_typed ? cur_result : want);
        sent_count++;
      end
      // Hold a word the block has not taken yet
      if (!(start && busy)) begin
        if (sent_count >= total_items) begin
          start <= 1'b0;
        end else if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else begin
          if (sent_count < dir_req.size()) begin
            request    <= dir_req[sent_count];
            cur_typed  = dir_typed[sent_count];
            cur_result = dir_result[sent_count];
          end else begin
            request   <= random_command();
            cur_typed = 1'b0;
          end
          start <= 1'b1;
          // Open a new burst once this one is spent
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end

    // Drain outstanding results, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word ok=%b allowed=%b caps=%h",
                 $time, result.ok, result.allowed, result.capabilities);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.ok !== want.ok) begin
          $display("%0t: ok expected %b, got %b", $time, want.ok, result.ok);
          errors++;
        end
        if (result.allowed !== want.allowed) begin
          $display("%0t: allowed expected %b, got %b", $time, want.allowed, result.allowed);
          errors++;
        end
        if (result.capabilities !== want.capabilities) begin
          $display("%0t: capabilities expected %h, got %h",
                   $time, want.capabilities, result.capabilities);
          errors++;
        end
      end
    end
  end

  // End the run if no word moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: capability_table_checker.f
rtl/ctc_pkg.sv
rtl/capability_table_checker.sv
test/testbench.sv
